>>> src/ip_address_scope_classifier_assert.svh
// ----------------------------------------------------------------------------
// ip_address_scope_classifier_assert
// Assertion macros used by the checker file of the address scope classifier.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_SCOPE_CLASSIFIER_ASSERT_SVH
`define IP_ADDRESS_SCOPE_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipsc assertion failed");

`endif

>>> src/ipsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsc_pkg
// Shared types and constants of the address scope classifier.
// ----------------------------------------------------------------------------
package ipsc_pkg;

  localparam int unsigned FamilyW = 2;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned ScopeW  = 3;

  localparam logic [FamilyW-1:0] FamOther = 2'd0;
  localparam logic [FamilyW-1:0] FamIpv4  = 2'd1;
  localparam logic [FamilyW-1:0] FamIpv6  = 2'd2;

  typedef enum logic [ScopeW-1:0] {
    ScopeNone      = 3'd0,
    ScopeMulticast = 3'd1,
    ScopeLoopback  = 3'd2,
    ScopePseudo    = 3'd3,
    ScopeGlobal    = 3'd4,
    ScopeLinkLocal = 3'd5,
    ScopePrivate   = 3'd6
  } scope_e;

  // Masked prefix compares for IPv4.
  localparam logic [31:0] Shared10Mask  = 32'hffc00000;
  localparam logic [31:0] Shared10Net   = 32'h64400000;
  localparam logic [31:0] Mask16        = 32'hffff0000;
  localparam logic [31:0] LinkLocalNet  = 32'ha9fe0000;
  localparam logic [31:0] Mask12        = 32'hfff00000;
  localparam logic [31:0] Priv172Net    = 32'hac100000;
  localparam logic [31:0] Priv192Net    = 32'hc0a80000;
  localparam logic [31:0] Mask24        = 32'hffffff00;
  localparam logic [31:0] TestNet1      = 32'hc0000200;
  localparam logic [31:0] Mask15        = 32'hfffe0000;
  localparam logic [31:0] BenchNet      = 32'hc6120000;
  localparam logic [31:0] TestNet2      = 32'hc6336400;
  localparam logic [31:0] TestNet3      = 32'hcb007100;

endpackage

>>> src/ip_address_scope_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_scope_classifier
// Classifies one IPv4 or IPv6 address per transfer into a scope code.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i/in_stall_o   family_i, addr_high_i, addr_low_i
//   output   out        out_valid_o/out_stall_i scope_o
//
// The block takes one transfer every clock cycle while in_stall_o is low and
// produces one result per transfer, through the input and result registers.
// The first register holds the incoming address; the decode between it and
// the result register is a handful of byte and prefix compares.
// Reset (rst_ni low, asynchronous) empties both stages; the block has no
// stored classification state.
// A stall on the output holds the result register; the input register keeps
// accepting until it too holds an item, and only then is in_stall_o raised.
// ----------------------------------------------------------------------------
module ip_address_scope_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ipsc_pkg::FamilyW-1:0] family_i,
  input  logic [ipsc_pkg::AddrW-1:0]   addr_high_i,
  input  logic [ipsc_pkg::AddrW-1:0]   addr_low_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ipsc_pkg::ScopeW-1:0]  scope_o
);

  // Input register stage.
  logic                         in_vld_q;
  logic [ipsc_pkg::FamilyW-1:0] family_q;
  logic [ipsc_pkg::AddrW-1:0]   addr_high_q;
  logic [ipsc_pkg::AddrW-1:0]   addr_low_q;

  // Result register stage.
  logic             res_vld_q;
  ipsc_pkg::scope_e scope_q;
  ipsc_pkg::scope_e scope_d;

  ipsc_pkg::scope_e v4_scope;
  ipsc_pkg::scope_e v6_scope;

  logic res_load;
  logic in_load;

  // The result register frees up when it is empty or its item leaves now;
  // the input register frees up when it is empty or its item moves on.
  assign res_load   = !res_vld_q || !out_stall_i;
  assign in_load    = !in_vld_q || res_load;
  assign in_stall_o = !in_load;

  ipsc_v4_class u_v4 (
    .addr_i  (addr_low_q[31:0]),
    .scope_o (v4_scope)
  );

  ipsc_v6_class u_v6 (
    .addr_high_i (addr_high_q),
    .addr_low_i  (addr_low_q),
    .scope_o     (v6_scope)
  );

  // Family select: any family other than IPv4 or IPv6 gives no scope.
  always_comb begin
    case (family_q)
      ipsc_pkg::FamIpv4: scope_d = v4_scope;
      ipsc_pkg::FamIpv6: scope_d = v6_scope;
      default:           scope_d = ipsc_pkg::ScopeNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_q <= in_valid_i;
      end
      if (res_load) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      family_q    <= family_i;
      addr_high_q <= addr_high_i;
      addr_low_q  <= addr_low_i;
    end
    if (res_load && in_vld_q) begin
      scope_q <= scope_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign scope_o     = scope_q;

endmodule

>>> src/ipsc_v4_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsc_v4_class
// Combinational IPv4 scope decode: first octet, then masked prefix compares.
// ----------------------------------------------------------------------------
module ipsc_v4_class (
  input  logic [31:0]     addr_i,
  output ipsc_pkg::scope_e scope_o
);

  logic [7:0] top;

  assign top = addr_i[31:24];

  always_comb begin
    // Octets that miss their prefix fall through to the top-nibble test.
    if (addr_i[31:28] == 4'he) begin
      scope_o = ipsc_pkg::ScopeMulticast;
    end else if (addr_i[31:28] == 4'hf) begin
      scope_o = ipsc_pkg::ScopePseudo;
    end else begin
      scope_o = ipsc_pkg::ScopeGlobal;
    end
    case (top)
      8'h00, 8'hff: scope_o = ipsc_pkg::ScopeNone;
      8'h06, 8'h0b, 8'h15, 8'h16, 8'h19, 8'h1a,
      8'h1c, 8'h1d, 8'h1e, 8'h33, 8'h37, 8'h38: scope_o = ipsc_pkg::ScopePseudo;
      8'h0a: scope_o = ipsc_pkg::ScopePrivate;
      8'h7f: scope_o = ipsc_pkg::ScopeLoopback;
      8'h64: begin
        if ((addr_i & ipsc_pkg::Shared10Mask) == ipsc_pkg::Shared10Net) begin
          scope_o = ipsc_pkg::ScopePrivate;
        end
      end
      8'ha9: begin
        if ((addr_i & ipsc_pkg::Mask16) == ipsc_pkg::LinkLocalNet) begin
          scope_o = ipsc_pkg::ScopeLinkLocal;
        end
      end
      8'hac: begin
        if ((addr_i & ipsc_pkg::Mask12) == ipsc_pkg::Priv172Net) begin
          scope_o = ipsc_pkg::ScopePrivate;
        end
      end
      8'hc0: begin
        if (((addr_i & ipsc_pkg::Mask16) == ipsc_pkg::Priv192Net) ||
            ((addr_i & ipsc_pkg::Mask24) == ipsc_pkg::TestNet1)) begin
          scope_o = ipsc_pkg::ScopePrivate;
        end
      end
      8'hc6: begin
        if (((addr_i & ipsc_pkg::Mask15) == ipsc_pkg::BenchNet) ||
            ((addr_i & ipsc_pkg::Mask24) == ipsc_pkg::TestNet2)) begin
          scope_o = ipsc_pkg::ScopePrivate;
        end
      end
      8'hcb: begin
        if ((addr_i & ipsc_pkg::Mask24) == ipsc_pkg::TestNet3) begin
          scope_o = ipsc_pkg::ScopePrivate;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/ipsc_v6_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsc_v6_class
// Combinational IPv6 scope decode on the leading bytes and the zero middle.
// ----------------------------------------------------------------------------
module ipsc_v6_class (
  input  logic [ipsc_pkg::AddrW-1:0] addr_high_i,
  input  logic [ipsc_pkg::AddrW-1:0] addr_low_i,
  output ipsc_pkg::scope_e           scope_o
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b15;
  logic       mid_zero;

  assign b0       = addr_high_i[63:56];
  assign b1       = addr_high_i[55:48];
  assign b15      = addr_low_i[7:0];
  assign mid_zero = (addr_high_i[47:0] == '0) && (addr_low_i[63:8] == '0);

  always_comb begin
    if (b0 == 8'hff) begin
      scope_o = ipsc_pkg::ScopeMulticast;
    end else if ((b0 == 8'hfe) && (b1[7:6] == 2'b10)) begin
      // Link-local with only byte 15 set to one is treated as loopback.
      scope_o = (mid_zero && (b15 == 8'h01)) ? ipsc_pkg::ScopeLoopback
                                             : ipsc_pkg::ScopeLinkLocal;
    end else if (b0[7:1] == 7'b1111110) begin
      scope_o = ipsc_pkg::ScopePrivate;
    end else if ((b0 == 8'h00) && (b1 == 8'h00) && mid_zero && (b15 == 8'h01)) begin
      scope_o = ipsc_pkg::ScopeLoopback;
    end else if ((b0 == 8'h00) && (b1 == 8'h00) && mid_zero && (b15 == 8'h00)) begin
      scope_o = ipsc_pkg::ScopeNone;
    end else begin
      scope_o = ipsc_pkg::ScopeGlobal;
    end
  end

endmodule

>>> src/ipsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsc_checker
// Port-level checks of the address scope classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "ip_address_scope_classifier_assert.svh"

module ipsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ipsc_pkg::ScopeW-1:0]  scope_o
);

  // The input only backs up when the result register is full and stalled.
  `IPSC_ASSERT_SAME(a_stall_needs_full_out, in_stall_o, out_valid_o && out_stall_i)

  // Code seven is never produced.
  `IPSC_ASSERT_SAME(a_scope_in_range, out_valid_o, scope_o != 3'd7)

  // A stalled result stays offered and unchanged.
  `IPSC_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)
  `IPSC_ASSERT_NEXT(a_out_scope_holds, out_valid_o && out_stall_i, $stable(scope_o))

endmodule

bind ip_address_scope_classifier ipsc_checker u_ipsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .scope_o     (scope_o)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4/IPv6 address scope classifier.
// ----------------------------------------------------------------------------
// A short table of hand-picked addresses comes first. It holds the field
// extremes, every family code, a prefix hit in each IPv4 special net and
// a near miss of the shared net, and the IPv6 special addresses. After it
// come about 450 random addresses, biased toward the special prefixes. Every
// accepted input transfer pushes its expected scope onto a queue. Each output
// transfer is compared with the oldest entry. Idling runs in three phases: a
// slow receiver, then a slow sender, then none. A long receiver hold-off
// backs up the pipeline into the input stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [ipsc_pkg::FamilyW-1:0] FamUnused = 2'd3;   // family code with no meaning

  localparam int DirectedRows  = 25;
  localparam int RandomPerPhase = 150;
  localparam int HoldOffCycles = 64;
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 200000;
  localparam int MaxReports    = 10;

  // One row of the directed table. When known is set, want is the scope typed
  // in by hand. Otherwise the predictor supplies the expectation.
  typedef struct packed {
    logic [ipsc_pkg::FamilyW-1:0] fam;
    logic [ipsc_pkg::AddrW-1:0]   hi;
    logic [ipsc_pkg::AddrW-1:0]   lo;
    logic                         known;
    ipsc_pkg::scope_e             want;
  } addr_case_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [ipsc_pkg::FamilyW-1:0] family_i;
  logic [ipsc_pkg::AddrW-1:0]   addr_high_i;
  logic [ipsc_pkg::AddrW-1:0]   addr_low_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [ipsc_pkg::ScopeW-1:0]  scope_o;

  ipsc_pkg::scope_e expected_scope [$];   // scopes still owed by the block, oldest first
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  int     send_idle_pct  = 0;   // chance in percent that the sender skips a cycle
  int     recv_idle_pct  = 0;   // chance in percent that the receiver stalls a cycle
  bit     hold_off_req   = 1'b0;
  int     fam_count   [4];
  int     scope_hits  [8];
  int     input_stalled_cycles = 0;

  ip_address_scope_classifier DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .family_i    (family_i),
    .addr_high_i (addr_high_i),
    .addr_low_i  (addr_low_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scope_o     (scope_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Scope of one address, worked out from the family and the prefix rules.
  function automatic ipsc_pkg::scope_e classify_scope(
      input logic [ipsc_pkg::FamilyW-1:0] fam,
      input logic [ipsc_pkg::AddrW-1:0]   hi,
      input logic [ipsc_pkg::AddrW-1:0]   lo);
    logic [31:0] ip;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        mid_zero;
    ip       = lo[31:0];
    b0       = hi[63:56];
    b1       = hi[55:48];
    mid_zero = (hi[47:0] == '0) && (lo[63:8] == '0);
    if (fam == ipsc_pkg::FamIpv4) begin
      // The top octet settles most classes. A special octet whose finer
      // prefix misses falls through to the top nibble tests.
      case (ip[31:24])
        8'h00, 8'hff: return ipsc_pkg::ScopeNone;
        8'h06, 8'h0b, 8'h15, 8'h16, 8'h19, 8'h1a,
        8'h1c, 8'h1d, 8'h1e, 8'h33, 8'h37, 8'h38: return ipsc_pkg::ScopePseudo;
        8'h0a: return ipsc_pkg::ScopePrivate;
        8'h7f: return ipsc_pkg::ScopeLoopback;
        8'h64:
          if ((ip & ipsc_pkg::Shared10Mask) == ipsc_pkg::Shared10Net)
            return ipsc_pkg::ScopePrivate;
        8'ha9:
          if ((ip & ipsc_pkg::Mask16) == ipsc_pkg::LinkLocalNet)
            return ipsc_pkg::ScopeLinkLocal;
        8'hac:
          if ((ip & ipsc_pkg::Mask12) == ipsc_pkg::Priv172Net)
            return ipsc_pkg::ScopePrivate;
        8'hc0: begin
          if ((ip & ipsc_pkg::Mask16) == ipsc_pkg::Priv192Net) return ipsc_pkg::ScopePrivate;
          if ((ip & ipsc_pkg::Mask24) == ipsc_pkg::TestNet1) return ipsc_pkg::ScopePrivate;
        end
        8'hc6: begin
          if ((ip & ipsc_pkg::Mask15) == ipsc_pkg::BenchNet) return ipsc_pkg::ScopePrivate;
          if ((ip & ipsc_pkg::Mask24) == ipsc_pkg::TestNet2) return ipsc_pkg::ScopePrivate;
        end
        8'hcb:
          if ((ip & ipsc_pkg::Mask24) == ipsc_pkg::TestNet3)
            return ipsc_pkg::ScopePrivate;
        default: ;
      endcase
      if (ip[31:28] == 4'he) return ipsc_pkg::ScopeMulticast;
      if (ip[31:28] == 4'hf) return ipsc_pkg::ScopePseudo;
      return ipsc_pkg::ScopeGlobal;
    end else if (fam == ipsc_pkg::FamIpv6) begin
      if (b0 == 8'hff) return ipsc_pkg::ScopeMulticast;
      // Only the top two bits of the second byte decide link-local. When
      // the rest of the address reads as 1, it counts as loopback.
      if (b0 == 8'hfe && b1[7:6] == 2'b10)
        return (mid_zero && lo[7:0] == 8'h01) ? ipsc_pkg::ScopeLoopback
                                              : ipsc_pkg::ScopeLinkLocal;
      if (b0[7:1] == 7'b1111110) return ipsc_pkg::ScopePrivate;
      if (b0 == 8'h00 && b1 == 8'h00 && mid_zero && lo[7:1] == 7'd0)
        return lo[0] ? ipsc_pkg::ScopeLoopback : ipsc_pkg::ScopeNone;
      return ipsc_pkg::ScopeGlobal;
    end
    return ipsc_pkg::ScopeNone;
  endfunction

  // Offers one address until the block takes it. Idle cycles are drawn before
  // valid rises. Once valid is up, the payload holds still until the transfer.
  task automatic send_addr(input logic [ipsc_pkg::FamilyW-1:0] fam,
                           input logic [ipsc_pkg::AddrW-1:0]   hi,
                           input logic [ipsc_pkg::AddrW-1:0]   lo,
                           input ipsc_pkg::scope_e             want);
    bit taken;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    family_i    = fam;
    addr_high_i = hi;
    addr_low_i  = lo;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (!taken) @(negedge clk_i);
    end
    expected_scope.push_back(want);
    fam_count[fam]++;
  endtask

  // Receiver: random stalls at the rate of the current phase. On request it
  // holds off for a long stretch, counted here, so the pipeline fills up.
  initial begin : stall_driver
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HoldOffCycles;
      end
      if (hold > 0) begin
        out_stall_i = 1'b1;
        hold--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every output transfer is matched against the oldest pending expectation.
  always @(posedge clk_i) begin : result_check
    ipsc_pkg::scope_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scope_hits[scope_o]++;
      if (expected_scope.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("mismatch: scope %0d arrived with no transfer pending", scope_o);
      end else begin
        want = expected_scope.pop_front();
        if (scope_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: scope expected %0d (%s), got %0d",
                     want, want.name(), scope_o);
        end
      end
    end
  end

  // Watchdog. The same process counts the cycles in which the input was
  // offered but refused.
  always @(posedge clk_i) begin
    cycle_count++;
    if (in_valid_i && in_stall_o) input_stalled_cycles++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_scope.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    addr_case_t                   directed_cases [DirectedRows];
    addr_case_t                   row;
    logic [ipsc_pkg::FamilyW-1:0] fam;
    logic [ipsc_pkg::AddrW-1:0]   hi;
    logic [ipsc_pkg::AddrW-1:0]   lo;
    logic [31:0]                  ip;
    int                           r;
    int                           bit_idx;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    family_i    = ipsc_pkg::FamOther;
    addr_high_i = '0;
    addr_low_i  = '0;

    // Directed table. Rows with known set carry a scope that can be read
    // straight off the rules. The rest rely on the predictor.
    directed_cases = '{
      '{ipsc_pkg::FamOther, '1, '1, 1'b1, ipsc_pkg::ScopeNone},
      '{FamUnused,          '1, '1, 1'b1, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, '0, 1'b1, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '1, '1, 1'b1, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '1, 64'hffff_ffff_0a00_0001, 1'b1, ipsc_pkg::ScopePrivate},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_7f00_0001, 1'b1, ipsc_pkg::ScopeLoopback},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_0601_0203, 1'b1, ipsc_pkg::ScopePseudo},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_6440_0000, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_6480_0001, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_a9fe_0101, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_ac1f_ffff, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_c0a8_0001, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_c000_02ff, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_c613_0000, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_c633_6407, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_cb00_7100, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_e000_0001, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv4,  '0, 64'h0000_0000_f000_0000, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv6,  64'hff02_0000_0000_0000, 64'h1, 1'b1, ipsc_pkg::ScopeMulticast},
      '{ipsc_pkg::FamIpv6,  64'hfe80_0000_0000_0000, 64'h1, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv6,  64'hfebf_0000_0000_0001, 64'h1, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv6,  64'hfd12_3456_789a_0000, 64'h0, 1'b0, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv6,  64'h0, 64'h1, 1'b1, ipsc_pkg::ScopeLoopback},
      '{ipsc_pkg::FamIpv6,  64'h0, 64'h0, 1'b1, ipsc_pkg::ScopeNone},
      '{ipsc_pkg::FamIpv6,  64'h2001_0db8_0000_0000, 64'h1, 1'b0, ipsc_pkg::ScopeNone}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase 0 idling also covers the directed rows.
    send_idle_pct = 17;
    recv_idle_pct = 81;
    for (int i = 0; i < DirectedRows; i++) begin
      row = directed_cases[i];
      send_addr(row.fam, row.hi, row.lo,
                row.known ? row.want : classify_scope(row.fam, row.hi, row.lo));
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 17; recv_idle_pct = 81; end
        1: begin send_idle_pct = 81; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        // With no idling, the receiver is asked for one long hold-off while
        // the sender keeps offering, so the input stall must rise.
        if (phase == 2 && n == 40) hold_off_req = 1'b1;

        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        r  = $urandom_range(99);
        if (r < 6) begin
          fam = r[0] ? ipsc_pkg::FamOther : FamUnused;
        end else if (r < 53) begin
          // IPv4. The upper bits of both words stay random because the
          // block must ignore them. Most picks land on a special prefix.
          fam = ipsc_pkg::FamIpv4;
          ip  = $urandom;
          case ($urandom_range(9))
            0: case ($urandom_range(11))
                 0: ip[31:24] = 8'h06;   1: ip[31:24] = 8'h0b;
                 2: ip[31:24] = 8'h15;   3: ip[31:24] = 8'h16;
                 4: ip[31:24] = 8'h19;   5: ip[31:24] = 8'h1a;
                 6: ip[31:24] = 8'h1c;   7: ip[31:24] = 8'h1d;
                 8: ip[31:24] = 8'h1e;   9: ip[31:24] = 8'h33;
                 10: ip[31:24] = 8'h37;  default: ip[31:24] = 8'h38;
               endcase
            1: ip[31:22] = {8'h64, 2'b01};
            2: ip[31:16] = 16'ha9fe;
            3: ip[31:20] = 12'hac1;
            4: ip[31:16] = 16'hc0a8;
            5: case ($urandom_range(2))
                 0: ip[31:8] = 24'hc00002;
                 1: ip[31:8] = 24'hc63364;
                 default: ip[31:8] = 24'hcb0071;
               endcase
            6: ip[31:17] = 15'h6309;   // 198.18.0.0/15
            7: case ($urandom_range(5))   // special octet, rest random: mostly a miss
                 0: ip[31:24] = 8'h64;   1: ip[31:24] = 8'ha9;
                 2: ip[31:24] = 8'hac;   3: ip[31:24] = 8'hc0;
                 4: ip[31:24] = 8'hc6;   default: ip[31:24] = 8'hcb;
               endcase
            8: case ($urandom_range(3))
                 0: ip[31:24] = 8'h00;   1: ip[31:24] = 8'h0a;
                 2: ip[31:24] = 8'h7f;   default: ip[31:24] = 8'hff;
               endcase
            default: ;
          endcase
          lo[31:0] = ip;
        end else begin
          fam = ipsc_pkg::FamIpv6;
          case ($urandom_range(9))
            0: hi[63:56] = 8'hff;
            1: hi[63:54] = 10'b1111_1110_10;
            2: begin
              // Link-local with a zero middle part: loopback only for a last byte of 1.
              hi = {10'b1111_1110_10, hi[53:48], 48'h0};
              lo = {56'h0, 8'($urandom_range(2))};
            end
            3: hi[63:57] = 7'b1111_110;
            4: begin
              hi = '0;
              lo = {56'h0, 8'($urandom_range(2))};
            end
            5: hi[63:60] = 4'hf;
            6: begin
              // One stray bit keeps the address just off the unspecified and
              // loopback addresses.
              hi = '0;
              lo = {56'h0, 7'h0, lo[0]};
              bit_idx = $urandom_range(8, 127);
              if (bit_idx < 64) lo[bit_idx] = 1'b1;
              else hi[bit_idx - 64] = 1'b1;
            end
            7: hi[63:56] = 8'hfe;
            default: ;
          endcase
        end
        send_addr(fam, hi, lo, classify_scope(fam, hi, lo));
      end
      // The sender rests until every result of this phase has come back.
      @(negedge clk_i);
      in_valid_i = 1'b0;
      while (expected_scope.size() != 0) @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    mismatch_count += expected_scope.size();

    $display("covered %0d transfers: %0d IPv4, %0d IPv6, %0d other family",
             fam_count[0] + fam_count[1] + fam_count[2] + fam_count[3],
             fam_count[ipsc_pkg::FamIpv4], fam_count[ipsc_pkg::FamIpv6],
             fam_count[ipsc_pkg::FamOther] + fam_count[FamUnused]);
    $display("input refused in %0d cycles; scopes seen: none %0d, multicast %0d,",
             input_stalled_cycles, scope_hits[ipsc_pkg::ScopeNone],
             scope_hits[ipsc_pkg::ScopeMulticast]);
    $display("  loopback %0d, pseudo %0d, global %0d, link-local %0d, private %0d",
             scope_hits[ipsc_pkg::ScopeLoopback], scope_hits[ipsc_pkg::ScopePseudo],
             scope_hits[ipsc_pkg::ScopeGlobal], scope_hits[ipsc_pkg::ScopeLinkLocal],
             scope_hits[ipsc_pkg::ScopePrivate]);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
